// File: sv/vcc_pkg.sv
`default_nettype none
package vcc_pkg;

  localparam int MAX_BYTES   = 5;
  localparam int GROUP_BITS  = 7;
  localparam int VALUE_W     = 32;
  localparam int LEN_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic OP_DECODE = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  localparam logic KIND_ENC = 1'b0;
  localparam logic KIND_DEC = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 2'd2;

  localparam logic [7:0] CONT_BIT = 8'h80;

  typedef struct packed {
    logic                 enc;
    logic [VALUE_W-1:0]   data;
    logic [LEN_W-1:0]     len;
    logic [STATUS_W-1:0]  status;
  } vcc_entry_t;

endpackage
`default_nettype wire

// File: sv/vcc_front.sv
`default_nettype none
module vcc_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_operation,
  input  logic [7:0]                 in_byte,
  input  logic                       in_buffer_end,
  input  logic signed [31:0]         in_value,
  input  logic                       q_ready,
  output logic                       push,
  output vcc_pkg::vcc_entry_t        push_entry
);
  import vcc_pkg::*;

  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic [LEN_W-1:0]   cnt_r, cnt_nxt;
  logic [VALUE_W-1:0] grp;
  logic [VALUE_W-1:0] acc_new;
  logic [6:0]         pay;
  logic               accept;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign pay      = in_byte[6:0];

  // place the 7-bit group by byte position, fifth byte keeps its low 4 bits
  always_comb begin
    case (cnt_r)
      3'd0:    grp = {25'b0, pay};
      3'd1:    grp = {18'b0, pay, 7'b0};
      3'd2:    grp = {11'b0, pay, 14'b0};
      3'd3:    grp = {4'b0, pay, 21'b0};
      default: grp = {pay[3:0], 28'b0};
    endcase
  end

  assign acc_new = acc_r | grp;

  always_comb begin
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    push       = 1'b0;
    push_entry = '0;
    if (accept) begin
      if (in_operation == OP_ENCODE) begin
        push            = 1'b1;
        push_entry.enc  = 1'b1;
        push_entry.data = in_value;
      end else if ((in_byte & CONT_BIT) == 8'h00) begin
        push              = 1'b1;
        push_entry.data   = acc_new;
        push_entry.len    = cnt_r + 3'd1;
        push_entry.status = ST_OK;
        acc_nxt           = '0;
        cnt_nxt           = '0;
      end else if (cnt_r == LEN_W'(MAX_BYTES - 1)) begin
        push              = 1'b1;
        push_entry.status = ST_TOO_LONG;
        acc_nxt           = '0;
        cnt_nxt           = '0;
      end else if (in_buffer_end) begin
        push              = 1'b1;
        push_entry.status = ST_INCOMPLETE;
        acc_nxt           = '0;
        cnt_nxt           = '0;
      end else begin
        acc_nxt = acc_new;
        cnt_nxt = cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/vcc_queue.sv
`default_nettype none
module vcc_queue #(
  parameter int DEPTH = vcc_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  vcc_pkg::vcc_entry_t push_entry,
  output logic                q_ready,
  input  logic                pop,
  output vcc_pkg::vcc_entry_t pop_entry,
  output logic                q_valid
);
  import vcc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  vcc_entry_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign q_ready   = (cnt_r != CNT_W'(DEPTH));
  assign q_valid   = (cnt_r != '0);
  assign pop_entry = mem[rd_r];
  assign do_push   = push && q_ready;
  assign do_pop    = pop && q_valid;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/vcc_back.sv
`default_nettype none
module vcc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  vcc_pkg::vcc_entry_t pop_entry,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_kind,
  output logic [7:0]          out_byte,
  output logic signed [31:0]  out_decoded_value,
  output logic [2:0]          out_byte_length,
  output logic [1:0]          out_status,
  output logic                out_last
);
  import vcc_pkg::*;

  logic               busy_r, busy_nxt;
  logic [VALUE_W-1:0] sh_r, sh_nxt;
  logic [LEN_W-1:0]   n_r, n_nxt;
  logic               vld_r, vld_nxt;
  logic               kind_r, kind_nxt;
  logic [7:0]         byte_r, byte_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [STATUS_W-1:0] st_r, st_nxt;
  logic               last_r, last_nxt;

  logic               can_load;
  logic               emit;
  logic [VALUE_W-1:0] src;
  logic [VALUE_W-1:0] rest;
  logic [LEN_W-1:0]   n_cur;
  logic               last_b;

  assign can_load = !vld_r || out_ready;
  assign pop      = !busy_r && q_valid && can_load;
  assign src      = busy_r ? sh_r : pop_entry.data;
  assign n_cur    = busy_r ? n_r : '0;
  assign rest     = src >> GROUP_BITS;
  assign last_b   = (rest == '0) || (n_cur == LEN_W'(MAX_BYTES - 1));
  // emit an encoded byte from a running job or from a fresh encode entry
  assign emit     = can_load && (busy_r || (q_valid && pop_entry.enc));

  always_comb begin
    busy_nxt = busy_r;
    sh_nxt   = sh_r;
    n_nxt    = n_r;
    vld_nxt  = vld_r && !out_ready;
    kind_nxt = kind_r;
    byte_nxt = byte_r;
    val_nxt  = val_r;
    len_nxt  = len_r;
    st_nxt   = st_r;
    last_nxt = last_r;
    if (emit) begin
      vld_nxt  = 1'b1;
      kind_nxt = KIND_ENC;
      byte_nxt = {!last_b, src[6:0]};
      val_nxt  = '0;
      len_nxt  = '0;
      st_nxt   = ST_OK;
      last_nxt = last_b;
      sh_nxt   = rest;
      n_nxt    = n_cur + 3'd1;
      busy_nxt = !last_b;
    end else if (pop) begin
      vld_nxt  = 1'b1;
      kind_nxt = KIND_DEC;
      byte_nxt = '0;
      val_nxt  = pop_entry.data;
      len_nxt  = pop_entry.len;
      st_nxt   = pop_entry.status;
      last_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      vld_r  <= vld_nxt;
    end
    sh_r   <= sh_nxt;
    n_r    <= n_nxt;
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
    val_r  <= val_nxt;
    len_r  <= len_nxt;
    st_r   <= st_nxt;
    last_r <= last_nxt;
  end

  assign out_valid         = vld_r;
  assign out_kind          = kind_r;
  assign out_byte          = byte_r;
  assign out_decoded_value = val_r;
  assign out_byte_length   = len_r;
  assign out_status        = st_r;
  assign out_last          = last_r;

endmodule
`default_nettype wire

// File: sv/varint_codec_core.sv
// 32-bit LEB128 varint codec. A decode transfer carries one byte; a value
// appears after its final byte, or a too-long / incomplete status at the
// fifth continued byte or at a continued byte marked buffer end. An encode
// transfer carries one 32-bit value and yields one to five bytes (ceil of
// significant bits / 7, at least one), one per cycle from the output register
// while out_ready holds. A queue of QUEUE_DEPTH entries sits between the front
// end and the byte emitter; the front end stalls only when that queue is full,
// and a decode byte that ends neither a value nor an error never enters it.
`default_nettype none
module varint_codec_core #(
  parameter int QUEUE_DEPTH = vcc_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic [7:0]         in_byte,
  input  logic               in_buffer_end,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic [7:0]         out_byte,
  output logic signed [31:0] out_decoded_value,
  output logic [2:0]         out_byte_length,
  output logic [1:0]         out_status,
  output logic               out_last
);
  import vcc_pkg::*;

  logic       q_ready;
  logic       q_valid;
  logic       push;
  logic       pop;
  vcc_entry_t push_entry;
  vcc_entry_t pop_entry;

  vcc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_byte       (in_byte),
    .in_buffer_end (in_buffer_end),
    .in_value      (in_value),
    .q_ready       (q_ready),
    .push          (push),
    .push_entry    (push_entry)
  );

  vcc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_valid    (q_valid)
  );

  vcc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .pop_entry         (pop_entry),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_byte          (out_byte),
    .out_decoded_value (out_decoded_value),
    .out_byte_length   (out_byte_length),
    .out_status        (out_status),
    .out_last          (out_last)
  );

  a_last_only_enc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_kind == KIND_ENC)
    else $error("last flag on a decode result");

  a_cont_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ENC |-> out_byte[7] == !out_last)
    else $error("continuation bit disagrees with last flag");

  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DEC && out_status == ST_OK
    |-> out_byte_length != 3'd0 && out_byte_length <= 3'(MAX_BYTES))
    else $error("decoded length out of range");

  a_err_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DEC && out_status != ST_OK
    |-> out_byte_length == 3'd0 && out_decoded_value == 32'sd0)
    else $error("error result carries data");

endmodule
`default_nettype wire
